@@ hw/rtl/gsu_pkg.sv @@
package gsu_pkg;

  // default geometry
  localparam int COORD_BITS = 24;
  localparam int DIR_BITS   = 32;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DOT,
    OP_CROSS,
    OP_NORM
  } dp_op_t;

  // wide operand source
  typedef enum logic [1:0] {
    U_DIR,
    U_T1,
    U_T2,
    U_NAR
  } usrc_t;

  // narrow vector select
  typedef enum logic [2:0] {
    N_P,
    N_AB,
    N_AC,
    N_AD,
    N_AO
  } nsel_t;

  // wide result destination
  typedef enum logic {
    D_T1,
    D_T2
  } dst_t;

  // simplex point moves
  typedef enum logic [2:0] {
    P_KEEP,
    P_SEED,
    P_PUSH,
    P_S1C,
    P_CD,
    P_DB,
    P_CB
  } perm_t;

  // result status codes
  localparam logic [1:0] ST_SEARCH = 2'd0;
  localparam logic [1:0] ST_HIT    = 2'd1;
  localparam logic [1:0] ST_MISS   = 2'd2;

  typedef struct packed {
    logic   go;
    dp_op_t op;
    usrc_t  usrc;
    nsel_t  un;
    nsel_t  vn;
    logic   neg;
    dst_t   dst;
    perm_t  perm;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic flag;
  } dp_sts_t;

endpackage

@@ hw/rtl/gsu_datapath.sv @@
module gsu_datapath #(
  parameter int COORD_BITS = gsu_pkg::COORD_BITS,
  parameter int DIR_BITS   = gsu_pkg::DIR_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pin_load,
  input  logic signed [COORD_BITS-1:0] pin_x,
  input  logic signed [COORD_BITS-1:0] pin_y,
  input  logic signed [COORD_BITS-1:0] pin_z,
  input  gsu_pkg::dp_cmd_t             cmd,
  output gsu_pkg::dp_sts_t             sts,
  output logic signed [DIR_BITS-1:0]   dir_x,
  output logic signed [DIR_BITS-1:0]   dir_y,
  output logic signed [DIR_BITS-1:0]   dir_z
);

  localparam int NB  = COORD_BITS + 1;
  localparam int WA  = 4 * COORD_BITS + 8;
  localparam int WD  = DIR_BITS + COORD_BITS + 4;
  localparam int WB  = (WA > WD) ? WA : WD;
  localparam int DG  = 8;
  localparam int ND  = (NB + DG - 1) / DG;
  localparam int VW  = ND * DG;
  localparam int DIW = (ND > 1) ? $clog2(ND) : 1;

  logic signed [COORD_BITS-1:0] s_r   [4][3];
  logic signed [COORD_BITS-1:0] pin_r [3];
  logic signed [DIR_BITS-1:0]   d_r   [3];
  logic signed [WB-1:0]         t1_r  [3];
  logic signed [WB-1:0]         t2_r  [3];
  logic signed [WB-1:0]         prod_r;
  logic signed [WB-1:0]         sum_r;

  gsu_pkg::dp_op_t op_r;
  gsu_pkg::usrc_t  usrc_r;
  gsu_pkg::nsel_t  un_r;
  gsu_pkg::nsel_t  vn_r;
  gsu_pkg::dst_t   dst_r;
  logic            neg_r;
  logic            busy_r;
  logic            acc_r;
  logic            done_r;
  logic            flag_r;
  logic [2:0]      k_r;
  logic [DIW-1:0]  dig_r;

  logic signed [NB-1:0] nab [3];
  logic signed [NB-1:0] nac [3];
  logic signed [NB-1:0] nad [3];
  logic signed [NB-1:0] nao [3];
  logic signed [NB-1:0] np  [3];
  logic signed [NB-1:0] nu  [3];
  logic signed [NB-1:0] nv  [3];
  logic signed [WB-1:0] u_vec [3];
  logic signed [WB-1:0] loadv [3];

  gsu_pkg::usrc_t usel;
  gsu_pkg::nsel_t unsel;

  logic [1:0]           ui;
  logic [1:0]           vi;
  logic                 tsub;
  logic signed [WB-1:0] ucomp;
  logic signed [NB-1:0] vcomp;
  logic signed [VW-1:0] vext;
  logic [DG-1:0]        slice;
  logic signed [DG:0]   dsig;
  logic signed [WB+DG:0] mulr;
  logic signed [WB-1:0] prodn;
  logic signed [WB-1:0] sumn;
  logic                 sum_pos;
  logic [2:0]           fit;

  assign sts.done = done_r;
  assign sts.flag = flag_r;
  assign dir_x = d_r[0];
  assign dir_y = d_r[1];
  assign dir_z = d_r[2];

  // edge vectors of the simplex, taken from the front point
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nab[i] = NB'(s_r[1][i]) - NB'(s_r[0][i]);
      nac[i] = NB'(s_r[2][i]) - NB'(s_r[0][i]);
      nad[i] = NB'(s_r[3][i]) - NB'(s_r[0][i]);
      nao[i] = -NB'(s_r[0][i]);
      np[i]  = NB'(pin_r[i]);
    end
  end

  assign usel  = busy_r ? usrc_r : cmd.usrc;
  assign unsel = busy_r ? un_r : cmd.un;

  // select narrow operands
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (unsel)
        gsu_pkg::N_AB: nu[i] = nab[i];
        gsu_pkg::N_AC: nu[i] = nac[i];
        gsu_pkg::N_AD: nu[i] = nad[i];
        gsu_pkg::N_AO: nu[i] = nao[i];
        default:       nu[i] = np[i];
      endcase
      case (vn_r)
        gsu_pkg::N_AB: nv[i] = nab[i];
        gsu_pkg::N_AC: nv[i] = nac[i];
        gsu_pkg::N_AD: nv[i] = nad[i];
        gsu_pkg::N_AO: nv[i] = nao[i];
        default:       nv[i] = np[i];
      endcase
    end
  end

  // select wide operand
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (usel)
        gsu_pkg::U_DIR: u_vec[i] = WB'(d_r[i]);
        gsu_pkg::U_T1:  u_vec[i] = t1_r[i];
        gsu_pkg::U_T2:  u_vec[i] = t2_r[i];
        default:        u_vec[i] = WB'(nu[i]);
      endcase
      loadv[i] = cmd.neg ? -u_vec[i] : u_vec[i];
    end
  end

  // product term schedule: cross takes two terms per component
  always_comb begin
    ui   = 2'd0;
    vi   = 2'd0;
    tsub = 1'b0;
    if (op_r == gsu_pkg::OP_CROSS) begin
      case (k_r)
        3'd0: begin ui = 2'd1; vi = 2'd2; end
        3'd1: begin ui = 2'd2; vi = 2'd1; tsub = 1'b1; end
        3'd2: begin ui = 2'd2; vi = 2'd0; end
        3'd3: begin ui = 2'd0; vi = 2'd2; tsub = 1'b1; end
        3'd4: begin ui = 2'd0; vi = 2'd1; end
        3'd5: begin ui = 2'd1; vi = 2'd0; tsub = 1'b1; end
        default: begin ui = 2'd0; vi = 2'd0; end
      endcase
    end else begin
      ui = k_r[1:0];
      vi = k_r[1:0];
    end
  end

  // digit-serial multiply, top digit first
  always_comb begin
    case (ui)
      2'd1:    ucomp = u_vec[1];
      2'd2:    ucomp = u_vec[2];
      default: ucomp = u_vec[0];
    endcase
    case (vi)
      2'd1:    vcomp = nv[1];
      2'd2:    vcomp = nv[2];
      default: vcomp = nv[0];
    endcase
    vext  = VW'(vcomp);
    slice = vext[dig_r*DG +: DG];
    dsig  = (dig_r == DIW'(ND - 1)) ? {slice[DG-1], slice} : {1'b0, slice};
    mulr  = ucomp * dsig;
    prodn = (prod_r <<< DG) + mulr[WB-1:0];
    sumn  = (tsub ^ neg_r) ? (sum_r - prod_r) : (sum_r + prod_r);
    sum_pos = !sumn[WB-1] && (|sumn);
    for (int i = 0; i < 3; i++) begin
      fit[i] = (&t1_r[i][WB-1:DIR_BITS-1]) | ~(|t1_r[i][WB-1:DIR_BITS-1]);
    end
  end

  // control registers of the shared unit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      flag_r <= 1'b0;
      for (int i = 0; i < 3; i++) d_r[i] <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.go && !busy_r) begin
        case (cmd.op)
          gsu_pkg::OP_NOP,
          gsu_pkg::OP_LOAD: done_r <= 1'b1;
          default:          busy_r <= 1'b1;
        endcase
      end else if (busy_r) begin
        case (op_r)
          gsu_pkg::OP_NORM: begin
            if (&fit) begin
              for (int i = 0; i < 3; i++) d_r[i] <= t1_r[i][DIR_BITS-1:0];
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          gsu_pkg::OP_DOT: begin
            if (acc_r && k_r == 3'd2) begin
              flag_r <= sum_pos;
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: begin
            if (acc_r && k_r == 3'd5) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pin_load) begin
      pin_r[0] <= pin_x;
      pin_r[1] <= pin_y;
      pin_r[2] <= pin_z;
    end
    if (cmd.go && !busy_r) begin
      // move simplex points
      case (cmd.perm)
        gsu_pkg::P_SEED: s_r[0] <= pin_r;
        gsu_pkg::P_PUSH: begin
          s_r[0] <= pin_r;
          s_r[1] <= s_r[0];
          s_r[2] <= s_r[1];
          s_r[3] <= s_r[2];
        end
        gsu_pkg::P_S1C: s_r[1] <= s_r[2];
        gsu_pkg::P_CD: begin
          s_r[1] <= s_r[2];
          s_r[2] <= s_r[3];
        end
        gsu_pkg::P_DB: begin
          s_r[1] <= s_r[3];
          s_r[2] <= s_r[1];
        end
        gsu_pkg::P_CB: begin
          s_r[1] <= s_r[2];
          s_r[2] <= s_r[1];
        end
        default: ;
      endcase
      if (cmd.op == gsu_pkg::OP_LOAD) begin
        if (cmd.dst == gsu_pkg::D_T1) t1_r <= loadv;
        else t2_r <= loadv;
      end
      op_r   <= cmd.op;
      usrc_r <= cmd.usrc;
      un_r   <= cmd.un;
      vn_r   <= cmd.vn;
      neg_r  <= cmd.neg;
      dst_r  <= cmd.dst;
      k_r    <= 3'd0;
      dig_r  <= DIW'(ND - 1);
      acc_r  <= 1'b0;
      prod_r <= '0;
      sum_r  <= '0;
    end else if (busy_r) begin
      if (op_r == gsu_pkg::OP_NORM) begin
        // halve all components until each fits
        if (!(&fit)) begin
          for (int i = 0; i < 3; i++) t1_r[i] <= t1_r[i] >>> 1;
        end
      end else if (!acc_r) begin
        prod_r <= prodn;
        if (dig_r == '0) acc_r <= 1'b1;
        else dig_r <= dig_r - 1'b1;
      end else begin
        // fold the finished product into the sum
        acc_r  <= 1'b0;
        prod_r <= '0;
        dig_r  <= DIW'(ND - 1);
        k_r    <= k_r + 3'd1;
        if (op_r == gsu_pkg::OP_CROSS && k_r[0]) begin
          if (dst_r == gsu_pkg::D_T1) t1_r[k_r[2:1]] <= sumn;
          else t2_r[k_r[2:1]] <= sumn;
          sum_r <= '0;
        end else begin
          sum_r <= sumn;
        end
      end
    end
  end

endmodule

@@ hw/rtl/gsu_ctrl.sv @@
module gsu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             in_kind,
  input  logic             slot_free,
  input  gsu_pkg::dp_sts_t sts,
  output gsu_pkg::dp_cmd_t cmd,
  output logic             idle,
  output logic             fin,
  output logic [1:0]       status,
  output logic [2:0]       size
);

  typedef enum logic [27:0] {
    S_IDLE  = 28'h0000001,
    S_SEED  = 28'h0000002,
    S_NXDOT = 28'h0000004,
    S_PUSH  = 28'h0000008,
    S_LNDOT = 28'h0000010,
    S_LNC1  = 28'h0000020,
    S_LNC2  = 28'h0000040,
    S_LNAO  = 28'h0000080,
    S_TRABC = 28'h0000100,
    S_TRC1  = 28'h0000200,
    S_TRD1  = 28'h0000400,
    S_TRD2  = 28'h0000800,
    S_TRPAC = 28'h0001000,
    S_TRC3  = 28'h0002000,
    S_TRD3  = 28'h0004000,
    S_TRD4  = 28'h0008000,
    S_TRUP  = 28'h0010000,
    S_TRDN  = 28'h0020000,
    S_TEC1  = 28'h0040000,
    S_TED1  = 28'h0080000,
    S_TEC2  = 28'h0100000,
    S_TED2  = 28'h0200000,
    S_TEP2  = 28'h0400000,
    S_TEC3  = 28'h0800000,
    S_TED3  = 28'h1000000,
    S_TEP3  = 28'h2000000,
    S_NORM  = 28'h4000000,
    S_FIN   = 28'h8000000
  } state_t;

  state_t     state_r, state_nxt;
  logic       pend_r, pend_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic [2:0] n_push;

  assign idle   = (state_r == S_IDLE);
  assign fin    = (state_r == S_FIN);
  assign status = stat_r;
  assign size   = cnt_r;
  assign n_push = (cnt_r >= 3'd4) ? 3'd4 : cnt_r + 3'd1;

  // command for the current step
  always_comb begin
    cmd.go   = !pend_r && (state_r != S_IDLE) && (state_r != S_FIN);
    cmd.op   = gsu_pkg::OP_NOP;
    cmd.usrc = gsu_pkg::U_NAR;
    cmd.un   = gsu_pkg::N_AB;
    cmd.vn   = gsu_pkg::N_AO;
    cmd.neg  = 1'b0;
    cmd.dst  = gsu_pkg::D_T1;
    cmd.perm = gsu_pkg::P_KEEP;
    case (state_r)
      S_SEED: begin
        cmd.op = gsu_pkg::OP_LOAD; cmd.un = gsu_pkg::N_P; cmd.neg = 1'b1;
        cmd.perm = gsu_pkg::P_SEED;
      end
      S_NXDOT: begin
        cmd.op = gsu_pkg::OP_DOT; cmd.usrc = gsu_pkg::U_DIR; cmd.vn = gsu_pkg::N_P;
      end
      S_PUSH:  cmd.perm = gsu_pkg::P_PUSH;
      S_LNDOT: cmd.op = gsu_pkg::OP_DOT;
      S_LNC1: begin
        cmd.op = gsu_pkg::OP_CROSS; cmd.dst = gsu_pkg::D_T2;
      end
      S_LNC2: begin
        cmd.op = gsu_pkg::OP_CROSS; cmd.usrc = gsu_pkg::U_T2; cmd.vn = gsu_pkg::N_AB;
      end
      S_LNAO: begin
        cmd.op = gsu_pkg::OP_LOAD; cmd.un = gsu_pkg::N_AO;
      end
      S_TRABC, S_TEC1: begin
        cmd.op = gsu_pkg::OP_CROSS; cmd.vn = gsu_pkg::N_AC; cmd.dst = gsu_pkg::D_T2;
      end
      S_TRC1: begin
        cmd.op = gsu_pkg::OP_CROSS; cmd.usrc = gsu_pkg::U_T2; cmd.vn = gsu_pkg::N_AC;
      end
      S_TRD1, S_TRD3: begin
        cmd.op = gsu_pkg::OP_DOT; cmd.usrc = gsu_pkg::U_T1;
      end
      S_TRD2: begin
        cmd.op = gsu_pkg::OP_DOT; cmd.un = gsu_pkg::N_AC;
      end
      S_TRPAC: cmd.perm = gsu_pkg::P_S1C;
      S_TRC3: begin
        cmd.op = gsu_pkg::OP_CROSS; cmd.usrc = gsu_pkg::U_T2; cmd.vn = gsu_pkg::N_AB;
        cmd.neg = 1'b1;
      end
      S_TRD4, S_TED1, S_TED2, S_TED3: begin
        cmd.op = gsu_pkg::OP_DOT; cmd.usrc = gsu_pkg::U_T2;
      end
      S_TRUP: begin
        cmd.op = gsu_pkg::OP_LOAD; cmd.usrc = gsu_pkg::U_T2;
      end
      S_TRDN: begin
        cmd.op = gsu_pkg::OP_LOAD; cmd.usrc = gsu_pkg::U_T2; cmd.neg = 1'b1;
        cmd.perm = gsu_pkg::P_CB;
      end
      S_TEC2: begin
        cmd.op = gsu_pkg::OP_CROSS; cmd.un = gsu_pkg::N_AC; cmd.vn = gsu_pkg::N_AD;
        cmd.dst = gsu_pkg::D_T2;
      end
      S_TEP2:  cmd.perm = gsu_pkg::P_CD;
      S_TEC3: begin
        cmd.op = gsu_pkg::OP_CROSS; cmd.un = gsu_pkg::N_AD; cmd.vn = gsu_pkg::N_AB;
        cmd.dst = gsu_pkg::D_T2;
      end
      S_TEP3:  cmd.perm = gsu_pkg::P_DB;
      S_NORM:  cmd.op = gsu_pkg::OP_NORM;
      default: ;
    endcase
  end

  // step sequencing on datapath completion
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    stat_nxt  = stat_r;
    pend_nxt  = pend_r;
    if (cmd.go) pend_nxt = 1'b1;
    if (sts.done) pend_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          stat_nxt  = gsu_pkg::ST_SEARCH;
          state_nxt = in_kind ? S_NXDOT : S_SEED;
        end
      end
      S_FIN: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: begin
        if (sts.done) begin
          case (state_r)
            S_SEED: begin cnt_nxt = 3'd1; state_nxt = S_NORM; end
            S_NXDOT: begin
              if (sts.flag) state_nxt = S_PUSH;
              else begin stat_nxt = gsu_pkg::ST_MISS; state_nxt = S_FIN; end
            end
            S_PUSH: begin
              cnt_nxt = n_push;
              case (n_push)
                3'd2:    state_nxt = S_LNDOT;
                3'd3:    state_nxt = S_TRABC;
                default: state_nxt = S_TEC1;
              endcase
            end
            S_LNDOT: state_nxt = sts.flag ? S_LNC1 : S_LNAO;
            S_LNC1:  state_nxt = S_LNC2;
            S_LNC2:  state_nxt = S_NORM;
            S_LNAO:  begin cnt_nxt = 3'd1; state_nxt = S_NORM; end
            S_TRABC: state_nxt = S_TRC1;
            S_TRC1:  state_nxt = S_TRD1;
            S_TRD1:  state_nxt = sts.flag ? S_TRD2 : S_TRC3;
            S_TRD2: begin
              if (sts.flag) state_nxt = S_TRPAC;
              else begin cnt_nxt = 3'd2; state_nxt = S_LNDOT; end
            end
            S_TRPAC: begin cnt_nxt = 3'd2; state_nxt = S_LNDOT; end
            S_TRC3:  state_nxt = S_TRD3;
            S_TRD3: begin
              if (sts.flag) begin cnt_nxt = 3'd2; state_nxt = S_LNDOT; end
              else state_nxt = S_TRD4;
            end
            S_TRD4:  state_nxt = sts.flag ? S_TRUP : S_TRDN;
            S_TRUP:  state_nxt = S_NORM;
            S_TRDN:  state_nxt = S_NORM;
            S_TEC1:  state_nxt = S_TED1;
            S_TED1: begin
              if (sts.flag) begin cnt_nxt = 3'd3; state_nxt = S_TRABC; end
              else state_nxt = S_TEC2;
            end
            S_TEC2:  state_nxt = S_TED2;
            S_TED2:  state_nxt = sts.flag ? S_TEP2 : S_TEC3;
            S_TEP2:  begin cnt_nxt = 3'd3; state_nxt = S_TRABC; end
            S_TEC3:  state_nxt = S_TED3;
            S_TED3: begin
              if (sts.flag) state_nxt = S_TEP3;
              else begin stat_nxt = gsu_pkg::ST_HIT; state_nxt = S_FIN; end
            end
            S_TEP3:  begin cnt_nxt = 3'd3; state_nxt = S_TRABC; end
            S_NORM:  state_nxt = S_FIN;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      cnt_r   <= 3'd0;
      stat_r  <= gsu_pkg::ST_SEARCH;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
      stat_r  <= stat_nxt;
    end
  end

endmodule

@@ hw/rtl/gjk_simplex_update.sv @@
// One update step of 3-D GJK collision detection per input transfer.
// Input channel: in_tuser is the kind (0 start, 1 next support point),
// in_tdata the support point, three signed fixed-point coordinates.
// Output channel: one transfer per input transfer, carrying the search
// direction held after the step, the status (0 keep searching, 1 collision,
// 2 no collision) and the simplex size.
// The block works on one item at a time. Every region test runs through one
// shared digit-serial multiply-accumulate unit, 8 bits of the narrow operand
// per cycle, ND = ceil((COORD_BITS+1)/8) digits (4 by default): a dot product
// sums three products, a cross product six, two per component, and the
// direction rescale halves all components until each fits.
// in_tready is high only while the block is idle; the result sits in an
// output register, so the block returns to idle while the receiver stalls
// as long as that register is free, and holds the finished result otherwise.
// Reset empties the simplex and zeroes the direction; no clearing pass.
module gjk_simplex_update #(
  parameter int COORD_BITS = gsu_pkg::COORD_BITS,
  parameter int DIR_BITS   = gsu_pkg::DIR_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // support_x, support_y, support_z
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]       in_tdata,
  // kind
  input  logic                                    in_tuser,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // dir_x, dir_y, dir_z, status, simplex_size
  output logic [((3*DIR_BITS+5+7)/8)*8-1:0]       out_tdata
);

  localparam int OW = ((3 * DIR_BITS + 5 + 7) / 8) * 8;

  gsu_pkg::dp_cmd_t cmd;
  gsu_pkg::dp_sts_t sts;

  logic                       in_fire;
  logic                       slot_free;
  logic                       fin;
  logic                       idle;
  logic [1:0]                 status;
  logic [2:0]                 size;
  logic signed [DIR_BITS-1:0] dir_x, dir_y, dir_z;
  logic                       out_tvalid_r;
  logic [OW-1:0]              out_tdata_r, out_tdata_nxt;

  assign in_tready  = idle;
  assign in_fire    = in_tvalid && idle;
  assign slot_free  = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  gsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_kind   (in_tuser),
    .slot_free (slot_free),
    .sts       (sts),
    .cmd       (cmd),
    .idle      (idle),
    .fin       (fin),
    .status    (status),
    .size      (size)
  );

  gsu_datapath #(
    .COORD_BITS (COORD_BITS),
    .DIR_BITS   (DIR_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .pin_load (in_fire),
    .pin_x    (in_tdata[COORD_BITS-1:0]),
    .pin_y    (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pin_z    (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .cmd      (cmd),
    .sts      (sts),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z)
  );

  // pack the result
  always_comb begin
    out_tdata_nxt = '0;
    out_tdata_nxt[DIR_BITS-1:0]              = dir_x;
    out_tdata_nxt[2*DIR_BITS-1:DIR_BITS]     = dir_y;
    out_tdata_nxt[3*DIR_BITS-1:2*DIR_BITS]   = dir_z;
    out_tdata_nxt[3*DIR_BITS+1:3*DIR_BITS]   = status;
    out_tdata_nxt[3*DIR_BITS+4:3*DIR_BITS+2] = size;
  end

  // hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (fin && slot_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && slot_free) out_tdata_r <= out_tdata_nxt;
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int CB        = 24;
  localparam int DB        = 32;
  localparam int IN_W      = ((3*CB+7)/8)*8;
  localparam int OUT_W     = ((3*DB+5+7)/8)*8;
  localparam int N_ITEMS   = 1300;
  localparam int MAX_CYC   = 6000000;
  localparam int MAX_SHOWN = 10;

  typedef logic signed [191:0] wint_t;
  typedef struct {
    wint_t x;
    wint_t y;
    wint_t z;
  } vec_t;

  typedef struct packed {
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic [1:0]  st;
    logic [2:0]  sz;
  } step_res_t;

  typedef struct packed {
    logic                 kind;
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
    logic signed [CB-1:0] pz;
    logic                 fixed;
    step_res_t            res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  gjk_simplex_update dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // GJK state mirror
  vec_t        simplex[4];
  int unsigned npts;
  vec_t        sdir;
  // scratch for one step
  vec_t        ws[4];
  int unsigned wn;
  vec_t        wd;

  step_res_t   expected_q[$];
  int          n_err;
  int          n_sent;
  int          n_hit;
  int          n_miss;
  int          n_search;
  longint      cyc = 0;
  bit          calm;
  // in_tvalid still high after the last transfer
  bit          held = 1'b0;

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec_t vneg(vec_t a);
    vec_t r;
    r.x = -a.x;
    r.y = -a.y;
    r.z = -a.z;
    return r;
  endfunction

  function automatic vec_t vcross(vec_t a, vec_t b);
    vec_t r;
    r.x = a.y*b.z - a.z*b.y;
    r.y = a.z*b.x - a.x*b.z;
    r.z = a.x*b.y - a.y*b.x;
    return r;
  endfunction

  function automatic wint_t vdot(vec_t a, vec_t b);
    return a.x*b.x + a.y*b.y + a.z*b.z;
  endfunction

  function automatic bit fits_dir(wint_t a);
    wint_t t;
    t = a >>> (DB-1);
    return (t == 0) || (t == -1);
  endfunction

  // shrink by common arithmetic shift until every component fits
  function automatic void keep_dir(vec_t d);
    while (!fits_dir(d.x) || !fits_dir(d.y) || !fits_dir(d.z)) begin
      d.x = d.x >>> 1;
      d.y = d.y >>> 1;
      d.z = d.z >>> 1;
    end
    sdir = d;
  endfunction

  function automatic void line_region();
    vec_t ab, ao;
    ab = vsub(ws[1], ws[0]);
    ao = vneg(ws[0]);
    if (vdot(ab, ao) > 0) begin
      wd = vcross(vcross(ab, ao), ab);
    end else begin
      wn = 1;
      wd = ao;
    end
  endfunction

  function automatic void tri_region();
    vec_t a, b, c, ab, ac, ao, abc;
    a = ws[0]; b = ws[1]; c = ws[2];
    ab = vsub(b, a);
    ac = vsub(c, a);
    ao = vneg(a);
    abc = vcross(ab, ac);
    if (vdot(vcross(abc, ac), ao) > 0) begin
      if (vdot(ac, ao) > 0) begin
        ws[1] = c;
        wn = 2;
        wd = vcross(vcross(ac, ao), ac);
      end else begin
        wn = 2;
        line_region();
      end
    end else if (vdot(vcross(ab, abc), ao) > 0) begin
      wn = 2;
      line_region();
    end else if (vdot(abc, ao) > 0) begin
      wd = abc;
    end else begin
      ws[1] = c;
      ws[2] = b;
      wd = vneg(abc);
    end
  endfunction

  // returns 1 when the origin is enclosed
  function automatic bit tetra_region();
    vec_t a, b, c, dd, ab, ac, ad, ao;
    a = ws[0]; b = ws[1]; c = ws[2]; dd = ws[3];
    ab = vsub(b, a);
    ac = vsub(c, a);
    ad = vsub(dd, a);
    ao = vneg(a);
    if (vdot(vcross(ab, ac), ao) > 0) begin
      wn = 3;
      tri_region();
      return 1'b0;
    end
    if (vdot(vcross(ac, ad), ao) > 0) begin
      ws[1] = c;
      ws[2] = dd;
      wn = 3;
      tri_region();
      return 1'b0;
    end
    if (vdot(vcross(ad, ab), ao) > 0) begin
      ws[1] = dd;
      ws[2] = b;
      wn = 3;
      tri_region();
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // advance the mirror by one support point, return the expected transfer
  function automatic step_res_t gjk_step(logic kind, logic signed [CB-1:0] px,
                                         logic signed [CB-1:0] py,
                                         logic signed [CB-1:0] pz);
    vec_t      p;
    step_res_t r;
    bit        hit;
    hit = 1'b0;
    p.x = px; p.y = py; p.z = pz;
    r.st = gsu_pkg::ST_SEARCH;
    if (!kind) begin
      simplex[0] = p;
      npts = 1;
      keep_dir(vneg(p));
    end else if (npts == 0 || !(vdot(p, sdir) > 0)) begin
      r.st = gsu_pkg::ST_MISS;
    end else begin
      ws[0] = p;
      for (int j = 1; j < 4; j++) ws[j] = simplex[j-1];
      wn = (npts >= 4) ? 4 : npts + 1;
      wd = sdir;
      if (wn == 2) line_region();
      else if (wn == 3) tri_region();
      else hit = tetra_region();
      for (int j = 0; j < 4; j++) simplex[j] = ws[j];
      npts = wn;
      if (hit) r.st = gsu_pkg::ST_HIT;
      else keep_dir(wd);
    end
    r.dx = sdir.x[31:0];
    r.dy = sdir.y[31:0];
    r.dz = sdir.z[31:0];
    r.sz = npts[2:0];
    return r;
  endfunction

  // drive one item and hold it until the transfer
  task automatic send_item(logic kind, logic signed [CB-1:0] px,
                           logic signed [CB-1:0] py, logic signed [CB-1:0] pz,
                           bit fixed, step_res_t typed);
    step_res_t pred;
    int        gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_W'({pz, py, px});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = gjk_step(kind, px, py, pz);
    expected_q.push_back(fixed ? typed : pred);
    n_sent++;
    case (pred.st)
      gsu_pkg::ST_HIT:  n_hit++;
      gsu_pkg::ST_MISS: n_miss++;
      default:          n_search++;
    endcase
    gap = 0;
    if (!calm) begin
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(15, 60);
      else if ($urandom_range(0, 1) == 0) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      held = 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      held = 1'b1;
    end
  endtask

  task automatic drain();
    if (held) begin
      in_tvalid <= 1'b0;
      held = 1'b0;
    end
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // convex cloud of eight corners, support = farthest along the direction
  logic signed [CB-1:0] cloud[8][3];

  task automatic new_cloud();
    int c[3];
    int h[3];
    int spread;
    spread = ($urandom_range(0, 1) == 0) ? 4096 : 200000;
    for (int k = 0; k < 3; k++) begin
      c[k] = $urandom_range(0, 2*spread) - spread;
      h[k] = $urandom_range(64, 150000);
    end
    for (int v = 0; v < 8; v++)
      for (int k = 0; k < 3; k++)
        cloud[v][k] = CB'(c[k] + (((v >> k) & 1) ? h[k] : -h[k])
                          + $urandom_range(0, 512) - 256);
  endtask

  task automatic support_of(vec_t d, output logic signed [CB-1:0] sp[3]);
    vec_t  q;
    wint_t best, v;
    int    bi;
    bi = 0;
    best = 0;
    for (int i = 0; i < 8; i++) begin
      q.x = cloud[i][0]; q.y = cloud[i][1]; q.z = cloud[i][2];
      v = vdot(q, d);
      if (i == 0 || v > best) begin
        best = v;
        bi = i;
      end
    end
    for (int k = 0; k < 3; k++) sp[k] = cloud[bi][k];
  endtask

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    step_res_t e;
    step_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
             out_tdata[97:96], out_tdata[100:98]};
      if (expected_q.size() == 0) begin
        n_err++;
        if (n_err <= MAX_SHOWN)
          $display("ERROR: unexpected result transfer %h", out_tdata);
      end else begin
        e = expected_q.pop_front();
        if (got != e) begin
          n_err++;
          if (n_err <= MAX_SHOWN)
            $display({"ERROR: dir exp %h %h %h got %h %h %h, ",
                      "status exp %0d got %0d, size exp %0d got %0d"},
                     e.dx, e.dy, e.dz, got.dx, got.dy, got.dz,
                     e.st, got.st, e.sz, got.sz);
        end
      end
    end
  end

  // receiver stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > MAX_CYC) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  stim_row_t rows[21];

  initial begin
    logic signed [CB-1:0] sp[3];
    vec_t                 d0;
    int                   steps;
    bit                   stop;
    step_res_t            r;
    n_err = 0; n_sent = 0; n_hit = 0; n_miss = 0; n_search = 0;
    calm = 1'b0;
    npts = 0;
    sdir.x = 0; sdir.y = 0; sdir.z = 0;

    // kind, x, y, z, typed, {dir_x, dir_y, dir_z, status, size}
    rows = '{
      '{1'b1, 24'sd100, 24'sd200, 24'sd300, 1'b1,
        {32'd0, 32'd0, 32'd0, gsu_pkg::ST_MISS, 3'd0}},
      '{1'b0, 24'sd256, 24'sd0, 24'sd0, 1'b1,
        {-32'sd256, 32'd0, 32'd0, gsu_pkg::ST_SEARCH, 3'd1}},
      '{1'b1, 24'sd256, 24'sd0, 24'sd0, 1'b1,
        {-32'sd256, 32'd0, 32'd0, gsu_pkg::ST_MISS, 3'd1}},
      // origin on the line: direction collapses to zero
      '{1'b1, -24'sd256, 24'sd0, 24'sd0, 1'b1,
        {32'd0, 32'd0, 32'd0, gsu_pkg::ST_SEARCH, 3'd2}},
      '{1'b1, 24'sd5, 24'sd6, 24'sd7, 1'b1,
        {32'd0, 32'd0, 32'd0, gsu_pkg::ST_MISS, 3'd2}},
      '{1'b0, 24'sd8388607, 24'sd8388607, 24'sd8388607, 1'b1,
        {-32'sd8388607, -32'sd8388607, -32'sd8388607, gsu_pkg::ST_SEARCH, 3'd1}},
      '{1'b0, -24'sd8388608, -24'sd8388608, -24'sd8388608, 1'b1,
        {32'sd8388608, 32'sd8388608, 32'sd8388608, gsu_pkg::ST_SEARCH, 3'd1}},
      '{1'b1, 24'sd8388607, -24'sd8388608, 24'sd8388607, 1'b0, '0},
      '{1'b1, -24'sd8388608, 24'sd8388607, 24'sd0, 1'b0, '0},
      '{1'b1, 24'sd0, -24'sd8388608, 24'sd8388607, 1'b0, '0},
      '{1'b1, 24'sd8388607, 24'sd8388607, -24'sd8388608, 1'b0, '0},
      '{1'b0, -24'sd1, -24'sd1, -24'sd1, 1'b1,
        {32'd1, 32'd1, 32'd1, gsu_pkg::ST_SEARCH, 3'd1}},
      // zero dot product counts as no progress
      '{1'b1, 24'sd0, 24'sd0, 24'sd0, 1'b1,
        {32'd1, 32'd1, 32'd1, gsu_pkg::ST_MISS, 3'd1}},
      // small tetrahedron around the origin
      '{1'b0, 24'sd1024, 24'sd1024, -24'sd512, 1'b0, '0},
      '{1'b1, -24'sd1024, 24'sd0, -24'sd512, 1'b0, '0},
      '{1'b1, 24'sd0, -24'sd1024, -24'sd512, 1'b0, '0},
      '{1'b1, 24'sd0, 24'sd0, 24'sd1024, 1'b0, '0},
      '{1'b1, 24'sd300, 24'sd300, 24'sd300, 1'b0, '0},
      '{1'b1, -24'sd700, 24'sd100, 24'sd50, 1'b0, '0},
      '{1'b1, 24'sd20, -24'sd900, -24'sd10, 1'b0, '0},
      '{1'b1, -24'sd5, -24'sd5, 24'sd2000, 1'b0, '0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      send_item(rows[i].kind, rows[i].px, rows[i].py, rows[i].pz,
                rows[i].fixed, rows[i].res);
    // hold off until the block has answered everything
    drain();

    r = '0;
    while (n_sent < N_ITEMS) begin
      if (n_sent % 200 < 40) calm = 1'b1;
      else calm = 1'b0;
      if ($urandom_range(0, 29) == 0) drain();
      if ($urandom_range(0, 99) < 15) begin
        // noise over the full field range
        send_item(1'($urandom_range(0, 1)), CB'($urandom), CB'($urandom),
                  CB'($urandom), 1'b0, r);
      end else begin
        new_cloud();
        d0.x = $signed($urandom_range(0, 2000)) - 1000;
        d0.y = $signed($urandom_range(0, 2000)) - 1000;
        d0.z = 1;
        support_of(d0, sp);
        send_item(1'b0, sp[0], sp[1], sp[2], 1'b0, r);
        stop = 1'b0;
        steps = 0;
        while (!stop && steps < 12) begin
          if ($urandom_range(0, 49) == 0) begin
            // broken sequence: an arbitrary point
            send_item(1'b1, CB'($urandom), CB'($urandom), CB'($urandom), 1'b0, r);
          end else begin
            support_of(sdir, sp);
            send_item(1'b1, sp[0], sp[1], sp[2], 1'b0, r);
          end
          if (expected_q.size() != 0 && expected_q[$].st != gsu_pkg::ST_SEARCH)
            stop = ($urandom_range(0, 3) != 0);
          steps++;
        end
      end
    end

    calm = 1'b0;
    drain();
    repeat (500) @(posedge clk);
    $display("Covered %0d support points: %0d searching, %0d collisions, %0d separations.",
             n_sent, n_search, n_hit, n_miss);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Mismatches: %0d, results still pending: %0d", n_err, expected_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/gsu_pkg.sv
hw/rtl/gsu_datapath.sv
hw/rtl/gsu_ctrl.sv
hw/rtl/gjk_simplex_update.sv
verif/tb_top.sv
